FILE: src/tcce_pkg.sv
// ----------------------------------------------------------------------------
// tcce_pkg
// Types, character codes and the microprogram of the text console cursor
// engine.
// ----------------------------------------------------------------------------
package tcce_pkg;

  // Character codes handled by the engine.
  localparam logic [7:0] CHAR_BS    = 8'h08;
  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [7:0] CHAR_VT    = 8'h0B;
  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_TILDE = 8'h7E;

  // Register file: one bit of the byte address selects the register.
  localparam int unsigned    PADDR_W  = 3;
  localparam logic           REG_COLS = 1'b0;
  localparam logic           REG_ROWS = 1'b1;
  localparam logic [6:0]     COLS_RESET = 7'd64;
  localparam logic [6:0]     ROWS_RESET = 7'd48;

  localparam int unsigned IN_DATA_W  = 56;
  localparam int unsigned OUT_DATA_W = 72;

  // Microprogram step addresses.
  typedef logic [2:0] step_t;
  localparam step_t STEP_IDLE   = 3'd0;
  localparam step_t STEP_PREP   = 3'd1;
  localparam step_t STEP_EMIT   = 3'd2;
  localparam step_t STEP_NOCELL = 3'd3;
  localparam step_t STEP_SCROLL = 3'd4;

  typedef enum logic [2:0] {
    COND_ALWAYS,
    COND_IN_VALID,
    COND_HAS_CELLS,
    COND_MORE_CELLS,
    COND_SCROLL
  } cond_e;

  // One control word of the microprogram.
  typedef struct packed {
    logic  in_ready;
    logic  prep;
    logic  emit_cell;
    logic  emit_scroll;
    cond_e cond;
    step_t jump_to;
    step_t fall_to;
  } ctrl_t;

  // Condition flags from the datapath.
  typedef struct packed {
    logic in_valid;
    logic has_cells;
    logic more_cells;
    logic scroll;
  } flags_t;

  function automatic ctrl_t useq_rom(step_t step);
    ctrl_t w;
    w = '{in_ready: 1'b0, prep: 1'b0, emit_cell: 1'b0, emit_scroll: 1'b0,
          cond: COND_ALWAYS, jump_to: STEP_IDLE, fall_to: STEP_IDLE};
    unique case (step)
      STEP_IDLE: begin
        w.in_ready = 1'b1;
        w.cond     = COND_IN_VALID;
        w.jump_to  = STEP_PREP;
        w.fall_to  = STEP_IDLE;
      end
      STEP_PREP: begin
        w.prep    = 1'b1;
        w.cond    = COND_HAS_CELLS;
        w.jump_to = STEP_EMIT;
        w.fall_to = STEP_NOCELL;
      end
      STEP_EMIT: begin
        w.emit_cell = 1'b1;
        w.cond      = COND_MORE_CELLS;
        w.jump_to   = STEP_EMIT;
        w.fall_to   = STEP_IDLE;
      end
      STEP_NOCELL: begin
        w.cond    = COND_SCROLL;
        w.jump_to = STEP_SCROLL;
        w.fall_to = STEP_IDLE;
      end
      STEP_SCROLL: begin
        w.emit_scroll = 1'b1;
        w.cond        = COND_ALWAYS;
        w.jump_to     = STEP_IDLE;
        w.fall_to     = STEP_IDLE;
      end
      default: begin
        w.cond    = COND_ALWAYS;
        w.jump_to = STEP_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage

FILE: src/tcce_useq.sv
// ----------------------------------------------------------------------------
// tcce_useq
// Microcode sequencer: step counter, control store and conditional jumps.
// ----------------------------------------------------------------------------
module tcce_useq (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            stall_i,
  input  tcce_pkg::flags_t flags_i,
  output tcce_pkg::ctrl_t  ctrl_o
);
  import tcce_pkg::*;

  step_t step_q, step_d;
  ctrl_t ctrl;
  logic  cond_true;

  assign ctrl   = useq_rom(step_q);
  assign ctrl_o = ctrl;

  always_comb begin
    case (ctrl.cond)
      COND_ALWAYS:     cond_true = 1'b1;
      COND_IN_VALID:   cond_true = flags_i.in_valid;
      COND_HAS_CELLS:  cond_true = flags_i.has_cells;
      COND_MORE_CELLS: cond_true = flags_i.more_cells;
      COND_SCROLL:     cond_true = flags_i.scroll;
      default:         cond_true = 1'b1;
    endcase
  end

  // A step that emits a result holds while the output register is full.
  always_comb begin
    if (stall_i) begin
      step_d = step_q;
    end else if (cond_true) begin
      step_d = ctrl.jump_to;
    end else begin
      step_d = ctrl.fall_to;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= STEP_IDLE;
    end else begin
      step_q <= step_d;
    end
  end

endmodule

FILE: src/text_console_cursor_engine_core.sv
// ----------------------------------------------------------------------------
// text_console_cursor_engine_core
// Keeps a text cursor in character cells and turns each character into
// cell-draw commands. An item is taken in the idle step, prepared in the next
// cycle, and the emit step then puts each drawn cell on the output register:
// one cell for a printable character, one per blank cell for a line feed or
// tab. An input that draws nothing passes a no-cell step, and a scroll step
// when it reports a scroll. New items are taken only in the idle step. The
// microcoded sequencer walks one cell per step. Output stalls stretch the
// emit and scroll steps. The scroll count rides on the last result of an input.
// ----------------------------------------------------------------------------
module text_console_cursor_engine_core #(
  parameter int unsigned MAX_COLUMNS = 64,
  parameter int unsigned MAX_ROWS    = 64,
  parameter int unsigned TAB_CELLS   = 4
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // Input tdata: char_code[7:0], fg_color[31:8], bg_color[55:32].
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [tcce_pkg::IN_DATA_W-1:0]      s_axis_tdata,
  // Output tdata: cell_column[5:0], cell_row[11:6], glyph_code[19:12],
  // draw_fg[43:20], draw_bg[67:44], scroll_rows[69:68], zero pad [71:70].
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [tcce_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
  // Output tuser: draw_valid.
  output logic                                m_axis_tuser,
  output logic                                m_axis_tlast,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [tcce_pkg::PADDR_W-1:0]        paddr,
  input  logic [31:0]                         pwdata,
  output logic [31:0]                         prdata,
  output logic                                pready
);
  import tcce_pkg::*;

  localparam logic [6:0] MaxCols = 7'(MAX_COLUMNS);
  localparam logic [6:0] MaxRows = 7'(MAX_ROWS);
  localparam logic [6:0] TabLen  = 7'(TAB_CELLS);

  // Configuration registers.
  logic [6:0] text_columns_q, text_rows_q;
  logic       cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;
  assign prdata    = (paddr[2] == REG_ROWS) ? {25'd0, text_rows_q} : {25'd0, text_columns_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      text_columns_q <= COLS_RESET;
      text_rows_q    <= ROWS_RESET;
    end else if (cfg_write) begin
      if (paddr[2] == REG_COLS) begin
        text_columns_q <= pwdata[6:0];
      end else begin
        text_rows_q <= pwdata[6:0];
      end
    end
  end

  // Sequencer.
  ctrl_t  ctrl;
  flags_t flags;
  logic   stall;
  logic   out_free;

  tcce_useq u_useq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .stall_i (stall),
    .flags_i (flags),
    .ctrl_o  (ctrl)
  );

  assign s_axis_tready = ctrl.in_ready;
  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign stall         = (ctrl.emit_cell || ctrl.emit_scroll) && !out_free;

  // Captured item and cursor state.
  logic [7:0]  code_q;
  logic [23:0] fg_q, bg_q;
  logic [6:0]  cursor_col_q;
  logic [5:0]  cursor_row_q;

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      code_q <= s_axis_tdata[7:0];
      fg_q   <= s_axis_tdata[31:8];
      bg_q   <= s_axis_tdata[55:32];
    end
  end

  // Preparation: wrap, decode the code, find the cell run and the scroll.
  logic [6:0] cols, rows;
  logic [6:0] row_c, row_w, col_w;
  logic       wrap;
  logic [6:0] tab_end;
  logic       p_has;
  logic [6:0] p_first, p_end, p_crow, f_col, f_row;
  logic [7:0] p_glyph;
  logic [6:0] scroll_w;
  logic [6:0] new_row;
  logic       p_has_eff;
  logic [6:0] p_out_row;

  always_comb begin
    cols = (text_columns_q == 7'd0) ? 7'd1 :
           (text_columns_q > MaxCols) ? MaxCols : text_columns_q;
    rows = (text_rows_q == 7'd0) ? 7'd1 :
           (text_rows_q > MaxRows) ? MaxRows : text_rows_q;
    row_c = ({1'b0, cursor_row_q} >= rows) ? rows - 7'd1 : {1'b0, cursor_row_q};
    wrap  = cursor_col_q >= cols;
    col_w = wrap ? 7'd0 : cursor_col_q;
    row_w = row_c + {6'd0, wrap};
    tab_end = ((col_w + TabLen) >= cols) ? cols : col_w + TabLen;

    p_has   = 1'b0;
    p_first = col_w;
    p_end   = col_w + 7'd1;
    p_crow  = row_w;
    p_glyph = CHAR_SPACE;
    f_col   = col_w;
    f_row   = row_w;

    case (code_q)
      CHAR_LF: begin
        p_has = 1'b1;
        p_end = cols;
        f_row = row_w + 7'd1;
        f_col = 7'd0;
      end
      CHAR_TAB: begin
        p_has = 1'b1;
        p_end = tab_end;
        f_col = tab_end;
      end
      CHAR_VT: begin
        f_row = row_w + 7'd1;
      end
      CHAR_CR: begin
        f_col = 7'd0;
      end
      CHAR_BS: begin
        if (col_w != 7'd0) begin
          p_has   = 1'b1;
          p_first = col_w - 7'd1;
          p_end   = col_w;
          f_col   = col_w - 7'd1;
        end else if (row_w != 7'd0) begin
          // From column 0 the cursor goes to the last cell of the row above.
          p_has   = 1'b1;
          p_first = cols - 7'd1;
          p_end   = cols;
          p_crow  = row_w - 7'd1;
          f_row   = row_w - 7'd1;
          f_col   = cols - 7'd1;
        end
      end
      default: begin
        if (code_q >= CHAR_SPACE && code_q <= CHAR_TILDE) begin
          p_has   = 1'b1;
          p_glyph = code_q;
          f_col   = col_w + 7'd1;
        end
      end
    endcase

    if (f_row >= rows) begin
      scroll_w = f_row - rows + 7'd1;
      new_row  = rows - 7'd1;
    end else begin
      scroll_w = 7'd0;
      new_row  = f_row;
    end
    // All cells of one input share a row; it is lost if it scrolls off.
    p_has_eff = p_has && (p_crow >= scroll_w);
    p_out_row = p_crow - scroll_w;
  end

  // Emit loop registers.
  logic [6:0] cur_col_q, end_col_q;
  logic [5:0] out_row_q;
  logic [7:0] glyph_q;
  logic [1:0] scroll_q;
  logic       more_cells;

  assign more_cells = (cur_col_q + 7'd1) < end_col_q;

  assign flags.in_valid   = s_axis_tvalid;
  assign flags.has_cells  = p_has_eff;
  assign flags.more_cells = more_cells;
  assign flags.scroll     = scroll_q != 2'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cursor_col_q <= 7'd0;
      cursor_row_q <= 6'd0;
    end else if (ctrl.prep) begin
      cursor_col_q <= f_col;
      cursor_row_q <= new_row[5:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.prep) begin
      cur_col_q <= p_first;
      end_col_q <= p_end;
      out_row_q <= p_out_row[5:0];
      glyph_q   <= p_glyph;
      scroll_q  <= scroll_w[1:0];
    end else if (ctrl.emit_cell && !stall) begin
      cur_col_q <= cur_col_q + 7'd1;
    end
  end

  // Output register.
  logic [5:0]  o_col_q, o_row_q;
  logic [7:0]  o_glyph_q;
  logic [23:0] o_fg_q, o_bg_q;
  logic [1:0]  o_scroll_q;
  logic        o_user_q, o_last_q, o_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      o_valid_q <= 1'b0;
    end else if ((ctrl.emit_cell || ctrl.emit_scroll) && out_free) begin
      o_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      o_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.emit_cell && out_free) begin
      o_user_q   <= 1'b1;
      o_col_q    <= cur_col_q[5:0];
      o_row_q    <= out_row_q;
      o_glyph_q  <= glyph_q;
      o_fg_q     <= fg_q;
      o_bg_q     <= bg_q;
      o_scroll_q <= more_cells ? 2'd0 : scroll_q;
      o_last_q   <= !more_cells;
    end else if (ctrl.emit_scroll && out_free) begin
      o_user_q   <= 1'b0;
      o_col_q    <= 6'd0;
      o_row_q    <= 6'd0;
      o_glyph_q  <= 8'd0;
      o_fg_q     <= 24'd0;
      o_bg_q     <= 24'd0;
      o_scroll_q <= scroll_q;
      o_last_q   <= 1'b1;
    end
  end

  assign m_axis_tvalid = o_valid_q;
  assign m_axis_tuser  = o_user_q;
  assign m_axis_tlast  = o_last_q;
  assign m_axis_tdata  = {2'b00, o_scroll_q, o_bg_q, o_fg_q, o_glyph_q, o_row_q, o_col_q};

endmodule

FILE: test/text_console_cursor_engine_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_console_cursor_engine_core_tb
// Self-checking bench for the text console cursor engine. A directed table of
// characters and screen settings runs first, then random text in several
// screen geometries. Every accepted character is run through a cursor model
// kept here, and each cell-draw transfer is compared against it field by
// field. Both stream sides idle at random; the APB port sets the geometry.
// ----------------------------------------------------------------------------
module text_console_cursor_engine_core_tb;
  import tcce_pkg::*;

  localparam int MAX_COLUMNS = 64;
  localparam int MAX_ROWS    = 64;
  localparam int TAB_CELLS   = 4;
  // A character that draws nothing may still be in the sequencer after the
  // last result has left.
  localparam int SETTLE_CYCLES = 8;
  localparam int END_CYCLES    = 16;
  // The longest quiet spell of a correct run is a settle plus four register
  // accesses.
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int ITEMS_PER_PHASE = 28;
  localparam int PHASES = 8;

  typedef struct packed {
    logic        draw_valid;
    logic [5:0]  cell_column;
    logic [5:0]  cell_row;
    logic [7:0]  glyph_code;
    logic [23:0] draw_fg;
    logic [23:0] draw_bg;
    logic [1:0]  scroll_rows;
    logic        last_result;
  } draw_cmd_t;

  typedef enum logic {ACT_ITEM, ACT_SETTING} act_e;

  typedef struct {
    act_e        act;
    logic [7:0]  code;
    logic [23:0] fg;
    logic [23:0] bg;
    logic [6:0]  cols;
    logic [6:0]  rows;
    bit          typed;
    bit          has_want;
    draw_cmd_t   want;
  } dir_row_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  m_axis_tuser;
  logic                  m_axis_tlast;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [PADDR_W-1:0]    paddr = '0;
  logic [31:0]           pwdata = '0;
  logic [31:0]           prdata;
  logic                  pready;

  // Cursor model state and its copy of the geometry registers.
  logic [6:0] cfg_cols = COLS_RESET;
  logic [6:0] cfg_rows = ROWS_RESET;
  logic [6:0] cursor_col = '0;
  logic [5:0] cursor_row = '0;

  draw_cmd_t expected_cmds[$];
  draw_cmd_t step_cmds[$];
  int        errors = 0;
  int        quiet_cycles = 0;
  int        rx_stall = 0;
  int        rx_burst = 0;
  draw_cmd_t rx_got;
  draw_cmd_t rx_want;

  text_console_cursor_engine_core #(
    .MAX_COLUMNS(MAX_COLUMNS),
    .MAX_ROWS   (MAX_ROWS),
    .TAB_CELLS  (TAB_CELLS)
  ) i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always #2 clk_i = ~clk_i;

  // Moves the cursor for one character and leaves its draw commands in
  // step_cmds.
  function automatic void predict_draws(logic [7:0] code, logic [23:0] fg,
                                        logic [23:0] bg);
    int         cols, rows, col, row, scroll, count, visible, emitted, k;
    int         buf_col[MAX_COLUMNS];
    int         buf_row[MAX_COLUMNS];
    logic [7:0] buf_glyph[MAX_COLUMNS];
    draw_cmd_t  cmd;
    cols = (cfg_cols == 0) ? 1 : ((cfg_cols > MAX_COLUMNS) ? MAX_COLUMNS : cfg_cols);
    rows = (cfg_rows == 0) ? 1 : ((cfg_rows > MAX_ROWS) ? MAX_ROWS : cfg_rows);
    col = cursor_col;
    row = cursor_row;
    count = 0;
    if (row >= rows) row = rows - 1;
    if (col >= cols) begin
      col = 0;
      row++;
    end
    case (code)
      CHAR_LF: begin
        for (k = col; k < cols; k++) begin
          buf_col[count] = k;
          buf_row[count] = row;
          buf_glyph[count] = CHAR_SPACE;
          count++;
        end
        row++;
        col = 0;
      end
      CHAR_TAB: begin
        for (k = 0; k < TAB_CELLS; k++) begin
          if (col < cols) begin
            buf_col[count] = col;
            buf_row[count] = row;
            buf_glyph[count] = CHAR_SPACE;
            count++;
            col++;
          end
        end
      end
      CHAR_VT: row++;
      CHAR_CR: col = 0;
      CHAR_BS: begin
        if (col > 0) begin
          col--;
          buf_col[count] = col;
          buf_row[count] = row;
          buf_glyph[count] = CHAR_SPACE;
          count++;
        end else if (row > 0) begin
          row--;
          col = cols - 1;
          buf_col[count] = col;
          buf_row[count] = row;
          buf_glyph[count] = CHAR_SPACE;
          count++;
        end
      end
      default: begin
        if (code >= CHAR_SPACE && code <= CHAR_TILDE) begin
          buf_col[count] = col;
          buf_row[count] = row;
          buf_glyph[count] = code;
          count++;
          col++;
        end
      end
    endcase
    scroll = 0;
    if (row >= rows) begin
      scroll = row - rows + 1;
      row = rows - 1;
    end
    cursor_col = col[6:0];
    cursor_row = row[5:0];

    // Cells that scrolled off the top are dropped.
    visible = 0;
    for (k = 0; k < count; k++) if (buf_row[k] >= scroll) visible++;
    emitted = 0;
    for (k = 0; k < count; k++) begin
      if (buf_row[k] >= scroll) begin
        emitted++;
        cmd.draw_valid  = 1'b1;
        cmd.cell_column = 6'(buf_col[k]);
        cmd.cell_row    = 6'(buf_row[k] - scroll);
        cmd.glyph_code  = buf_glyph[k];
        cmd.draw_fg     = fg;
        cmd.draw_bg     = bg;
        cmd.scroll_rows = (emitted == visible) ? 2'(scroll) : 2'd0;
        cmd.last_result = (emitted == visible);
        step_cmds.push_back(cmd);
      end
    end
    if (visible == 0 && scroll > 0) begin
      cmd = '0;
      cmd.scroll_rows = 2'(scroll);
      cmd.last_result = 1'b1;
      step_cmds.push_back(cmd);
    end
  endfunction

  function automatic void check_field(string name, logic [23:0] want, logic [23:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0h, actual %0h", name, want, got);
      errors++;
    end
  endfunction

  // Output side: check each transfer, then draw the stall before the next.
  always @(posedge clk_i) begin
    if (m_axis_tvalid && m_axis_tready) begin
      rx_got.draw_valid  = m_axis_tuser;
      rx_got.cell_column = m_axis_tdata[5:0];
      rx_got.cell_row    = m_axis_tdata[11:6];
      rx_got.glyph_code  = m_axis_tdata[19:12];
      rx_got.draw_fg     = m_axis_tdata[43:20];
      rx_got.draw_bg     = m_axis_tdata[67:44];
      rx_got.scroll_rows = m_axis_tdata[69:68];
      rx_got.last_result = m_axis_tlast;
      if (expected_cmds.size() == 0) begin
        $error("draw command with nothing expected: %0h", rx_got);
        errors++;
      end else begin
        rx_want = expected_cmds.pop_front();
        check_field("draw_valid", rx_want.draw_valid, rx_got.draw_valid);
        check_field("cell_column", rx_want.cell_column, rx_got.cell_column);
        check_field("cell_row", rx_want.cell_row, rx_got.cell_row);
        check_field("glyph_code", rx_want.glyph_code, rx_got.glyph_code);
        check_field("draw_fg", rx_want.draw_fg, rx_got.draw_fg);
        check_field("draw_bg", rx_want.draw_bg, rx_got.draw_bg);
        check_field("scroll_rows", rx_want.scroll_rows, rx_got.scroll_rows);
        check_field("last_result", rx_want.last_result, rx_got.last_result);
      end
      if (rx_burst > 0) begin
        rx_burst--;
        rx_stall = 0;
      end else begin
        rx_stall = $urandom_range(0, 8);
        if ($urandom_range(0, 15) == 0) rx_burst = 40;
      end
    end
    if (rx_stall > 0) begin
      m_axis_tready <= 1'b0;
      rx_stall--;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Offers one character after a random gap and records what it should draw.
  // A typed row replaces the model's output with the value from the table.
  task automatic send_item(input logic [7:0] code, input logic [23:0] fg,
                           input logic [23:0] bg, input int gap, input bit typed,
                           input bit has_want, input draw_cmd_t want);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {bg, fg, code};
    do @(posedge clk_i); while (!s_axis_tready);
    predict_draws(code, fg, bg);
    if (typed) begin
      if (has_want) expected_cmds.push_back(want);
    end else begin
      foreach (step_cmds[i]) expected_cmds.push_back(step_cmds[i]);
    end
    step_cmds.delete();
  endtask

  // Holds the input back until every expected command has come out.
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (expected_cmds.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // APB write followed by a read back of the same register.
  task automatic write_register(input logic sel, input logic [6:0] value);
    logic [31:0] word;
    word = {25'($urandom()), value};
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= {sel, 2'b00};
    pwdata  <= word;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== {25'd0, value}) begin
      $error("prdata mismatch: expected %0h, actual %0h", {25'd0, value}, prdata);
      errors++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic write_settings(input logic [6:0] cols, input logic [6:0] rows);
    write_register(REG_COLS, cols);
    write_register(REG_ROWS, rows);
    cfg_cols = cols;
    cfg_rows = rows;
  endtask

  function automatic dir_row_t predicted(logic [7:0] code);
    dir_row_t r;
    r = '{ACT_ITEM, code, 24'($urandom()), 24'($urandom()), '0, '0, 1'b0, 1'b0, '0};
    return r;
  endfunction

  function automatic dir_row_t silent(logic [7:0] code);
    dir_row_t r;
    r = '{ACT_ITEM, code, 24'($urandom()), 24'($urandom()), '0, '0, 1'b1, 1'b0, '0};
    return r;
  endfunction

  function automatic dir_row_t drawn(logic [7:0] code, logic [23:0] fg, logic [23:0] bg,
                                     logic [5:0] col, logic [5:0] row, logic [7:0] glyph,
                                     logic [1:0] scroll);
    dir_row_t r;
    r = '{ACT_ITEM, code, fg, bg, '0, '0, 1'b1, 1'b1,
          '{1'b1, col, row, glyph, fg, bg, scroll, 1'b1}};
    return r;
  endfunction

  function automatic dir_row_t scrolled(logic [7:0] code, logic [1:0] scroll);
    dir_row_t r;
    r = '{ACT_ITEM, code, 24'($urandom()), 24'($urandom()), '0, '0, 1'b1, 1'b1,
          '{1'b0, 6'd0, 6'd0, 8'd0, 24'd0, 24'd0, scroll, 1'b1}};
    return r;
  endfunction

  function automatic dir_row_t setting(logic [6:0] cols, logic [6:0] rows);
    dir_row_t r;
    r = '{ACT_SETTING, '0, '0, '0, cols, rows, 1'b0, 1'b0, '0};
    return r;
  endfunction

  initial begin : stimulus
    dir_row_t    directed[$];
    dir_row_t    d;
    logic [7:0]  code;
    logic [6:0]  ph_cols, ph_rows;
    int          pick, counted, tx_burst, gap;

    // Reset geometry is 64 columns by 48 rows with the cursor at the origin.
    directed.push_back(drawn(8'h41, 24'hFFFFFF, 24'h000000, 6'd0, 6'd0, 8'h41, 2'd0));
    directed.push_back(drawn(CHAR_TILDE, 24'h000000, 24'hFFFFFF, 6'd1, 6'd0, CHAR_TILDE,
                             2'd0));
    directed.push_back(drawn(CHAR_SPACE, 24'h5A5A5A, 24'hA5A5A5, 6'd2, 6'd0, CHAR_SPACE,
                             2'd0));
    directed.push_back(silent(8'h7F));
    directed.push_back(silent(8'h1F));
    directed.push_back(silent(8'hFF));
    directed.push_back(silent(8'h00));
    directed.push_back(silent(CHAR_CR));
    // Backspace at the origin neither moves nor draws.
    directed.push_back(silent(CHAR_BS));
    directed.push_back(drawn(8'h78, 24'h00FF00, 24'hFF00FF, 6'd0, 6'd0, 8'h78, 2'd0));
    directed.push_back(drawn(CHAR_BS, 24'h0000FF, 24'hFFFF00, 6'd0, 6'd0, CHAR_SPACE, 2'd0));
    directed.push_back(silent(CHAR_VT));
    // Backspace from column 0 goes to the last cell of the row above.
    directed.push_back(drawn(CHAR_BS, 24'h800000, 24'h000080, 6'd63, 6'd0, CHAR_SPACE,
                             2'd0));
    // Tab in the last column draws one blank and parks the cursor past the end.
    directed.push_back(drawn(CHAR_TAB, 24'h7FFFFF, 24'h800001, 6'd63, 6'd0, CHAR_SPACE,
                             2'd0));
    directed.push_back(drawn(8'h5A, 24'h010203, 24'hFEFDFC, 6'd0, 6'd1, 8'h5A, 2'd0));
    directed.push_back(predicted(CHAR_TAB));
    directed.push_back(predicted(CHAR_LF));
    // A line feed from column 0 draws a full row of blanks.
    directed.push_back(predicted(CHAR_LF));
    // One cell on a one-row screen: every wrap scrolls.
    directed.push_back(setting(7'd1, 7'd1));
    directed.push_back(drawn(8'h41, 24'hFFFFFF, 24'h000000, 6'd0, 6'd0, 8'h41, 2'd0));
    directed.push_back(drawn(8'h42, 24'h123456, 24'h654321, 6'd0, 6'd0, 8'h42, 2'd1));
    directed.push_back(scrolled(CHAR_VT, 2'd2));
    // The blanks of this line feed scroll off the top before they are drawn.
    directed.push_back(scrolled(CHAR_LF, 2'd1));
    directed.push_back(silent(CHAR_BS));
    directed.push_back(drawn(CHAR_TAB, 24'hABCDEF, 24'hFEDCBA, 6'd0, 6'd0, CHAR_SPACE, 2'd0));
    // The cursor sits past the only column, so the wrap scrolls before the return.
    directed.push_back(scrolled(CHAR_CR, 2'd1));

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed[i]) begin
      d = directed[i];
      if (d.act == ACT_SETTING) begin
        settle();
        write_settings(d.cols, d.rows);
      end else begin
        send_item(d.code, d.fg, d.bg, $urandom_range(0, 8), d.typed, d.has_want, d.want);
      end
    end

    tx_burst = 0;
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0:       begin ph_cols = 7'd127; ph_rows = 7'd127; end
        1:       begin ph_cols = 7'd0;   ph_rows = 7'd0;   end
        2:       begin ph_cols = 7'd1;   ph_rows = 7'd64;  end
        3:       begin ph_cols = 7'd64;  ph_rows = 7'd1;   end
        4:       begin ph_cols = 7'd5;   ph_rows = 7'd3;   end
        5:       begin ph_cols = 7'd64;  ph_rows = 7'd64;  end
        default: begin
          ph_cols = 7'($urandom_range(0, 127));
          ph_rows = 7'($urandom_range(0, 127));
        end
      endcase
      settle();
      write_settings(ph_cols, ph_rows);
      counted = 0;
      while (counted < ITEMS_PER_PHASE) begin
        pick = $urandom_range(0, 99);
        if (pick < 55)      code = 8'($urandom_range(CHAR_SPACE, CHAR_TILDE));
        else if (pick < 65) code = CHAR_LF;
        else if (pick < 73) code = CHAR_TAB;
        else if (pick < 79) code = CHAR_VT;
        else if (pick < 85) code = CHAR_CR;
        else if (pick < 93) code = CHAR_BS;
        else                code = 8'($urandom());
        if ((code >= CHAR_SPACE && code <= CHAR_TILDE) || code == CHAR_LF ||
            code == CHAR_TAB || code == CHAR_VT || code == CHAR_CR || code == CHAR_BS) begin
          counted++;
        end
        if (tx_burst > 0) begin
          tx_burst--;
          gap = 0;
        end else begin
          gap = $urandom_range(0, 8);
          if ($urandom_range(0, 11) == 0) tx_burst = 12;
        end
        send_item(code, 24'($urandom()), 24'($urandom()), gap, 1'b0, 1'b0, '0);
        // Let the output side run dry at least once in every phase.
        if (counted == ITEMS_PER_PHASE / 2) settle();
      end
    end

    settle();
    repeat (END_CYCLES) @(posedge clk_i);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
